// ----- design/gfcm_pkg.sv -----
package gfcm_pkg;

    // Fixed widths of the item fields and of the scaled-mode datapath
    localparam int unsigned COORD_W    = 6;
    localparam int unsigned GRID_W     = 7;
    localparam int unsigned CMAP_W     = 16;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned SAMPLE_W   = DATA_W + 1;
    localparam int unsigned SUM_W      = DATA_W + 2;
    localparam int unsigned DIFF_W     = DATA_W + 3;
    localparam int unsigned DEN_W      = DATA_W + 2;
    localparam int unsigned NUM_W      = DIFF_W + CMAP_W;
    localparam int unsigned N_W        = NUM_W + 2;
    localparam int unsigned DIVISOR_W  = DEN_W + 1;
    localparam int unsigned QUOT_W     = 17;
    localparam int unsigned COLOR_W    = 17;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Default sizes handed to the top level
    localparam int MAX_COLS_DEF  = 64;
    localparam int MAX_ROWS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMAP_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALED_MODE = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] low;
        logic signed [DATA_W-1:0] high;
    } t_range;

    typedef struct packed {
        logic              ovf;
        logic              neg;
        logic [QUOT_W-1:0] quot;
        logic              rem_nz;
    } t_div_res;

endpackage

// ----- design/gfcm_store.sv -----
module gfcm_store #(
    parameter int unsigned DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic [gfcm_pkg::SAMPLE_W-1:0]     i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    output logic [gfcm_pkg::SAMPLE_W-1:0]     o_rd_data
);
    import gfcm_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/gfcm_range.sv -----
module gfcm_range (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic                                i_restart,
    input  logic                                i_in_store,
    input  logic                                i_finite,
    input  logic signed [gfcm_pkg::DATA_W-1:0]  i_z,
    output gfcm_pkg::t_range                    o_range
);
    import gfcm_pkg::*;

    logic                     r_seen;
    logic signed [DATA_W-1:0] r_low;
    logic signed [DATA_W-1:0] r_high;
    logic                     n_seen;
    logic signed [DATA_W-1:0] n_low;
    logic signed [DATA_W-1:0] n_high;
    logic                     w_seen;
    logic signed [DATA_W-1:0] w_low;
    logic signed [DATA_W-1:0] w_high;

    // A restart clears the range before the sample itself is tracked.
    always_comb begin
        w_seen = i_restart ? 1'b0 : r_seen;
        w_low  = i_restart ? '0 : r_low;
        w_high = i_restart ? '0 : r_high;
        n_seen = w_seen;
        n_low  = w_low;
        n_high = w_high;
        if (i_in_store && i_finite) begin
            priority if (!w_seen) begin
                n_seen = 1'b1;
                n_low  = i_z;
                n_high = i_z;
            end else if (i_z > w_high) begin
                n_high = i_z;
            end else if (i_z < w_low) begin
                n_low = i_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_low  <= '0;
            r_high <= '0;
        end else if (i_load) begin
            r_seen <= n_seen;
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    assign o_range.low  = r_low;
    assign o_range.high = r_high;

endmodule

// ----- design/gfcm_div.sv -----
module gfcm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [gfcm_pkg::N_W-1:0]     i_num,
    input  logic [gfcm_pkg::DIVISOR_W-1:0]      i_den,
    output logic                                o_done,
    output gfcm_pkg::t_div_res                  o_res
);
    import gfcm_pkg::*;

    localparam int unsigned MAG_W  = N_W - 1;
    localparam int unsigned STEP_W = $clog2(QUOT_W);

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_CHECK = 2'd1;
    localparam logic [1:0] D_ITER  = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [STEP_W-1:0]    r_step;
    logic                 r_done;
    logic                 r_neg;
    logic                 r_ovf;
    logic [MAG_W-1:0]     r_mag;
    logic [DIVISOR_W-1:0] r_d;
    logic [DIVISOR_W-1:0] r_rem;
    logic [QUOT_W-1:0]    r_qd;

    logic [N_W-1:0]       w_negated;
    logic                 w_ovf;
    logic [DIVISOR_W:0]   w_trial;
    logic [DIVISOR_W:0]   w_diff;
    logic                 w_ge;

    assign w_negated = -i_num;
    // The quotient fits in QUOT_W bits exactly when the magnitude is below d * 2^QUOT_W.
    assign w_ovf     = r_mag >= {r_d, {QUOT_W{1'b0}}};
    assign w_trial   = {r_rem, r_qd[QUOT_W-1]};
    assign w_diff    = w_trial - {1'b0, r_d};
    assign w_ge      = w_trial >= {1'b0, r_d};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE:  if (i_start) n_state = D_CHECK;
            D_CHECK: n_state = w_ovf ? D_IDLE : D_ITER;
            D_ITER:  if (r_step == '0) n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == D_CHECK) && w_ovf) ||
                       ((r_state == D_ITER) && (r_step == '0));
            if (r_state == D_CHECK) begin
                r_step <= STEP_W'(QUOT_W - 1);
            end else if (r_state == D_ITER) begin
                r_step <= r_step - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == D_IDLE) && i_start) begin
            r_neg <= i_num[N_W-1];
            r_mag <= i_num[N_W-1] ? w_negated[MAG_W-1:0] : i_num[MAG_W-1:0];
            r_d   <= i_den;
        end
        if (r_state == D_CHECK) begin
            r_ovf <= w_ovf;
            r_rem <= r_mag[MAG_W-1:QUOT_W];
            r_qd  <= r_mag[QUOT_W-1:0];
        end
        if (r_state == D_ITER) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_qd  <= {r_qd[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done       = r_done;
    assign o_res.ovf    = r_ovf;
    assign o_res.neg    = r_neg;
    assign o_res.quot   = r_qd;
    assign o_res.rem_nz = (r_rem != '0);

endmodule

// ----- design/grid_facet_color_mapper_top.sv -----
// Grid facet colour mapper. Load words write one signed Q16.16 height sample, with its finite
// flag, into a synchronous sample store with one write and one read port and update the
// running minimum and maximum of the finite samples; a load yields no result word.
// Query words name a facet by its lower corner and yield exactly one result word. In scaled
// mode the four corners are read one per cycle from the store, summed, offset by the tracked
// minimum, multiplied by (colours - 1) and divided by four times the tracked span (at least
// one LSB) with round-half-up, and one is added to the quotient; the division is a restoring
// divider that produces one quotient bit per cycle, so most of a scaled query is spent in the
// 17 divider steps. In direct mode only the lower corner is read and its integer part,
// toward zero, is returned. A facet outside the configured grid is answered with the
// out-of-grid flag, and a non-finite corner gives the invalid flag
// with colour 0. Colours saturate to -32768..65535. While a query is in flight the input
// stalls, which also keeps store writes and corner reads from ever overlapping. A finished
// result sits in an output register, so the next word is accepted while it waits to be taken.
// The store is not cleared after reset: a query must only touch samples that have been loaded.
// Configuration words are taken at any time but must only be written while the block is idle.
module grid_facet_color_mapper_top #(
    parameter int MAX_COLS  = gfcm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = gfcm_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = gfcm_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // item input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_command,
    input  logic [gfcm_pkg::COORD_W-1:0]           i_col,
    input  logic [gfcm_pkg::COORD_W-1:0]           i_row,
    input  logic signed [gfcm_pkg::DATA_W-1:0]     i_z_value,
    input  logic                                   i_z_finite,
    input  logic                                   i_restart_range,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [gfcm_pkg::COLOR_W-1:0]    o_color_index,
    output logic                                   o_facet_invalid,
    output logic                                   o_out_of_grid,
    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [gfcm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gfcm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import gfcm_pkg::*;

    localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    localparam logic signed [32:0] COLOR_MIN = -33'sd32768;
    localparam logic signed [32:0] COLOR_MAX = 33'sd65535;
    localparam logic signed [32:0] FRAC_MASK = 33'((64'sd1 <<< FRAC_BITS) - 64'sd1);

    localparam logic [2:0] CORNERS_SCALED = 3'd4;
    localparam logic [2:0] CORNERS_DIRECT = 3'd1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_READ    = 3'd1;
    localparam logic [2:0] S_DIFF    = 3'd2;
    localparam logic [2:0] S_MUL     = 3'd3;
    localparam logic [2:0] S_SUM     = 3'd4;
    localparam logic [2:0] S_DIVGO   = 3'd5;
    localparam logic [2:0] S_DIVWAIT = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    function automatic logic signed [COLOR_W-1:0] sat_color(input logic signed [32:0] v);
        logic signed [COLOR_W-1:0] res;
        if (v < COLOR_MIN) begin
            res = COLOR_MIN[COLOR_W-1:0];
        end else if (v > COLOR_MAX) begin
            res = COLOR_MAX[COLOR_W-1:0];
        end else begin
            res = v[COLOR_W-1:0];
        end
        return res;
    endfunction

    // Control and configuration
    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [GRID_W-1:0]       r_grid_cols;
    logic [GRID_W-1:0]       r_grid_rows;
    logic [CMAP_W-1:0]       r_cmap_size;
    logic                    r_scaled_mode;
    logic [2:0]              r_issue;
    logic                    r_rd_valid;
    logic                    r_out_valid;

    // Query datapath
    logic [ADDR_W-1:0]       r_base;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_fin;
    logic signed [DIFF_W-1:0] r_diff;
    logic [DEN_W-1:0]        r_den;
    logic signed [NUM_W-1:0] r_num;
    logic signed [N_W-1:0]   r_n;
    logic signed [COLOR_W-1:0] r_res_color;
    logic                    r_res_inv;
    logic                    r_res_oog;
    logic signed [COLOR_W-1:0] r_out_color;
    logic                    r_out_inv;
    logic                    r_out_oog;

    logic                    w_acc;
    logic                    w_acc_load;
    logic                    w_acc_query;
    logic                    w_in_store;
    logic                    w_oog;
    logic [ADDR_W-1:0]       w_addr;
    logic [2:0]              w_ncorners;
    logic                    w_rd_en;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic [SAMPLE_W-1:0]     w_rd_data;
    logic signed [SUM_W-1:0] w_sum_nx;
    logic                    w_fin_nx;
    logic                    w_last;
    logic                    w_out_free;
    t_range                  w_range;
    logic signed [32:0]      w_dv;
    logic signed [32:0]      w_bias;
    logic signed [32:0]      w_dt;
    logic signed [32:0]      w_dsh;
    logic signed [COLOR_W-1:0] w_direct_color;
    logic signed [DIFF_W-1:0] w_sum_x;
    logic signed [DIFF_W-1:0] w_low4;
    logic signed [32:0]      w_span;
    logic [DATA_W-1:0]       w_span_fl;
    logic [CMAP_W-1:0]       w_cm1;
    logic signed [NUM_W:0]   w_prod;
    logic signed [N_W-1:0]   w_n;
    logic                    w_div_done;
    t_div_res                w_div_res;
    logic signed [18:0]      w_q;
    logic signed [18:0]      w_c;
    logic signed [COLOR_W-1:0] w_scaled_color;

    // Input side: every word is taken in the idle state, loads complete on acceptance.
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_acc_load  = w_acc && (i_command == CMD_LOAD);
    assign w_acc_query = w_acc && (i_command == CMD_QUERY);

    assign w_in_store = (int'(i_col) < MAX_COLS) && (int'(i_row) < MAX_ROWS);
    assign w_addr     = ADDR_W'(int'(i_row) * MAX_COLS + int'(i_col));

    // A facet needs the sample to its right and the one above, inside both grid and store.
    assign w_oog = ({1'b0, i_col} + 7'd1 >= r_grid_cols) ||
                   ({1'b0, i_row} + 7'd1 >= r_grid_rows) ||
                   (int'(i_col) + 1 >= MAX_COLS) || (int'(i_row) + 1 >= MAX_ROWS);

    gfcm_range u_range (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_acc_load),
        .i_restart  (i_restart_range),
        .i_in_store (w_in_store),
        .i_finite   (i_z_finite),
        .i_z        (i_z_value),
        .o_range    (w_range)
    );

    // Corner reads: one per cycle, lower-left, lower-right, upper-left, upper-right.
    assign w_ncorners = r_scaled_mode ? CORNERS_SCALED : CORNERS_DIRECT;
    assign w_rd_en    = (r_state == S_READ) && (r_issue != w_ncorners);
    assign w_rd_addr  = r_base + (r_issue[0] ? ADDR_W'(1) : '0) +
                        (r_issue[1] ? ADDR_W'(MAX_COLS) : '0);

    gfcm_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_acc_load && w_in_store),
        .i_wr_addr (w_addr),
        .i_wr_data ({i_z_finite, i_z_value}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_sum_nx = r_sum + {{(SUM_W-DATA_W){w_rd_data[DATA_W-1]}}, w_rd_data[DATA_W-1:0]};
    assign w_fin_nx = r_fin && w_rd_data[DATA_W];
    assign w_last   = r_rd_valid && (r_issue == w_ncorners);

    // Direct colour: integer part toward zero, by biasing negative values before the shift.
    assign w_dv           = {w_rd_data[DATA_W-1], w_rd_data[DATA_W-1:0]};
    assign w_bias         = w_rd_data[DATA_W-1] ? FRAC_MASK : 33'sd0;
    assign w_dt           = w_dv + w_bias;
    assign w_dsh          = w_dt >>> FRAC_BITS;
    assign w_direct_color = sat_color(w_dsh);

    // Scaled colour: numerator (C-1)*(S-4L), denominator 4*max(span,1).
    assign w_sum_x   = {r_sum[SUM_W-1], r_sum};
    assign w_low4    = {w_range.low[DATA_W-1], w_range.low, 2'b00};
    assign w_span    = {w_range.high[DATA_W-1], w_range.high} -
                       {w_range.low[DATA_W-1], w_range.low};
    assign w_span_fl = (w_span < 33'sd1) ? DATA_W'(1) : w_span[DATA_W-1:0];
    assign w_cm1     = (r_cmap_size == '0) ? '0 : r_cmap_size - 1'b1;
    assign w_prod    = r_diff * $signed({1'b0, w_cm1});
    assign w_n       = {r_num[NUM_W-1], r_num, 1'b0} + {{(N_W-DEN_W){1'b0}}, r_den};

    gfcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_num   (r_n),
        .i_den   ({r_den, 1'b0}),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    // Floor division of a negative numerator rounds the magnitude up when a remainder is left.
    assign w_q = w_div_res.neg ?
                 -({2'b00, w_div_res.quot} + {18'd0, w_div_res.rem_nz}) :
                 {2'b00, w_div_res.quot};
    assign w_c = w_q + 19'sd1;
    assign w_scaled_color = w_div_res.ovf ?
                            (w_div_res.neg ? COLOR_MIN[COLOR_W-1:0] : COLOR_MAX[COLOR_W-1:0]) :
                            sat_color({{14{w_c[18]}}, w_c});

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_query) begin
                    n_state = w_oog ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                if (w_last) begin
                    n_state = (w_fin_nx && r_scaled_mode) ? S_DIFF : S_DONE;
                end
            end
            S_DIFF:    n_state = S_MUL;
            S_MUL:     n_state = S_SUM;
            S_SUM:     n_state = S_DIVGO;
            S_DIVGO:   n_state = S_DIVWAIT;
            S_DIVWAIT: if (w_div_done) n_state = S_DONE;
            S_DONE:    if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_grid_cols   <= 7'd2;
            r_grid_rows   <= 7'd2;
            r_cmap_size   <= 16'd32;
            r_scaled_mode <= 1'b1;
            r_issue       <= '0;
            r_rd_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_GRID_COLS:   r_grid_cols   <= i_cfg_data[GRID_W-1:0];
                    CFG_GRID_ROWS:   r_grid_rows   <= i_cfg_data[GRID_W-1:0];
                    CFG_CMAP_SIZE:   r_cmap_size   <= i_cfg_data[CMAP_W-1:0];
                    CFG_SCALED_MODE: r_scaled_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_acc_query) begin
                r_issue    <= '0;
                r_rd_valid <= 1'b0;
            end else begin
                r_rd_valid <= w_rd_en;
                if (w_rd_en) begin
                    r_issue <= r_issue + 1'b1;
                end
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_query) begin
            r_base      <= w_addr;
            r_sum       <= '0;
            r_fin       <= 1'b1;
            r_res_color <= '0;
            r_res_inv   <= 1'b0;
            r_res_oog   <= w_oog;
        end
        if ((r_state == S_READ) && r_rd_valid) begin
            r_sum <= w_sum_nx;
            r_fin <= w_fin_nx;
            if (w_last) begin
                r_res_inv   <= !w_fin_nx;
                r_res_color <= (w_fin_nx && !r_scaled_mode) ? w_direct_color : '0;
            end
        end
        if (r_state == S_DIFF) begin
            r_diff <= w_sum_x - w_low4;
            r_den  <= {w_span_fl, 2'b00};
        end
        if (r_state == S_MUL) begin
            r_num <= w_prod[NUM_W-1:0];
        end
        if (r_state == S_SUM) begin
            r_n <= w_n;
        end
        if ((r_state == S_DIVWAIT) && w_div_done) begin
            r_res_color <= w_scaled_color;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_color <= r_res_color;
            r_out_inv   <= r_res_inv;
            r_out_oog   <= r_res_oog;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_color_index   = r_out_color;
    assign o_facet_invalid = r_out_inv;
    assign o_out_of_grid   = r_out_oog;

endmodule

// ----- design/gfcm_checker.sv -----
module gfcm_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  i_command,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [gfcm_pkg::COLOR_W-1:0]   o_color_index,
    input logic                                  o_facet_invalid,
    input logic                                  o_out_of_grid
);
    import gfcm_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_color_index) &&
        $stable(o_facet_invalid) && $stable(o_out_of_grid))
        else $error("stalled result word changed");

    // The two flags never appear together.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_facet_invalid && o_out_of_grid))
        else $error("invalid and out-of-grid flags both set");

    // A flagged result carries colour zero.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_facet_invalid || o_out_of_grid) |-> o_color_index == '0)
        else $error("flagged result with non-zero colour");

    // An accepted query occupies the block for at least the following cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_QUERY) |=> o_in_stall)
        else $error("input not stalled after a query");

endmodule

bind grid_facet_color_mapper_top gfcm_checker u_checker (.*);

// ----- tb/grid_facet_color_mapper_top_tb.sv -----
// Self-checking bench for the grid facet colour mapper.
//
// Words are driven on the falling clock edge and every handshake is sampled on the rising
// edge. A behavioural copy of the sample store, the tracked height range and the four
// configuration registers is kept here. Every load word accepted by the block is applied to
// that copy at once. Every query word accepted by the block queues the colour that the copy
// predicts. A separate process drains the result channel under random back-pressure and
// compares each result word, field by field, with the oldest queued prediction.
module grid_facet_color_mapper_top_tb;
    import gfcm_pkg::*;

    localparam int          CLK_HALF        = 6;
    localparam int          RESET_CYCLES    = 11;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    // A scaled query is the slowest operation, so this is ample.
    localparam int          SETTLE_CYCLES   = 40;
    localparam int          MAX_GAP         = 17;
    localparam int          REPORT_LIMIT    = 10;
    localparam int          PHASE_COUNT     = 10;
    localparam int          WORDS_PER_PHASE = 70;
    localparam int          STORE_COLS      = MAX_COLS_DEF;
    localparam int          STORE_ROWS      = MAX_ROWS_DEF;
    localparam int          STORE_DEPTH     = STORE_COLS * STORE_ROWS;
    localparam longint      FRAC_ONE        = longint'(1) << FRAC_BITS_DEF;
    localparam longint      COLOR_LO        = -32768;
    localparam longint      COLOR_HI        = 65535;

    typedef struct packed {
        logic signed [COLOR_W-1:0] color;
        logic                      invalid;
        logic                      off_grid;
    } facet_result_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_command;
    logic [COORD_W-1:0]          i_col;
    logic [COORD_W-1:0]          i_row;
    logic signed [DATA_W-1:0]    i_z_value;
    logic                        i_z_finite;
    logic                        i_restart_range;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [COLOR_W-1:0]   o_color_index;
    logic                        o_facet_invalid;
    logic                        o_out_of_grid;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;

    // Behavioural copy of the block's state and configuration.
    logic [SAMPLE_W-1:0]         sample_mem [STORE_DEPTH];
    bit                          loaded     [STORE_DEPTH];
    logic signed [DATA_W-1:0]    span_low;
    logic signed [DATA_W-1:0]    span_high;
    bit                          span_seen;
    logic [GRID_W-1:0]           grid_cols_q;
    logic [GRID_W-1:0]           grid_rows_q;
    logic [CMAP_W-1:0]           cmap_size_q;
    logic                        scaled_q;

    // Colours predicted for accepted queries and not yet seen on the result channel.
    facet_result_t               colors_due [$];
    int                          mismatch_count = 0;
    int unsigned                 cycle_count = 0;
    // When set, the sender or the receiver runs back to back without idle cycles.
    bit                          tx_steady;
    bit                          rx_steady;

    grid_facet_color_mapper_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_col           (i_col),
        .i_row           (i_row),
        .i_z_value       (i_z_value),
        .i_z_finite      (i_z_finite),
        .i_restart_range (i_restart_range),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_color_index   (o_color_index),
        .o_facet_invalid (o_facet_invalid),
        .o_out_of_grid   (o_out_of_grid),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog: a hung handshake must not leave the run spinning for ever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------------------

    function automatic longint sample_height(input logic [SAMPLE_W-1:0] entry);
        logic signed [DATA_W-1:0] z;
        z = entry[DATA_W-1:0];
        return longint'(z);
    endfunction

    function automatic logic signed [COLOR_W-1:0] clamp_color(input longint v);
        if (v < COLOR_LO) begin
            v = COLOR_LO;
        end else if (v > COLOR_HI) begin
            v = COLOR_HI;
        end
        return v[COLOR_W-1:0];
    endfunction

    // A load always lands in the store, since the coordinate ports cannot exceed its size.
    // A restart clears the tracked range before the new sample is considered.
    function automatic void store_sample(input int unsigned col, input int unsigned row,
                                         input logic [DATA_W-1:0] z, input logic fin,
                                         input logic restart);
        logic signed [DATA_W-1:0] h;
        h = z;
        if (restart) begin
            span_seen = 1'b0;
            span_low  = '0;
            span_high = '0;
        end
        sample_mem[row * STORE_COLS + col] = {fin, z};
        loaded[row * STORE_COLS + col]     = 1'b1;
        if (fin) begin
            if (!span_seen) begin
                span_low  = h;
                span_high = h;
                span_seen = 1'b1;
            end else if (h > span_high) begin
                span_high = h;
            end else if (h < span_low) begin
                span_low = h;
            end
        end
    endfunction

    function automatic facet_result_t predict_facet(input int unsigned col,
                                                    input int unsigned row);
        facet_result_t res;
        int unsigned   base;
        int unsigned   corner [4];
        longint        sum;
        longint        colors;
        longint        span;
        longint        num;
        longint        den;
        longint        quot;
        res = '0;
        if (col + 1 >= grid_cols_q || row + 1 >= grid_rows_q ||
            col + 1 >= STORE_COLS || row + 1 >= STORE_ROWS) begin
            res.off_grid = 1'b1;
            return res;
        end
        base = row * STORE_COLS + col;
        // Direct mode looks at the lower corner only and truncates toward zero.
        if (!scaled_q) begin
            if (!sample_mem[base][DATA_W]) begin
                res.invalid = 1'b1;
            end else begin
                res.color = clamp_color(sample_height(sample_mem[base]) / FRAC_ONE);
            end
            return res;
        end
        corner = '{base, base + 1, base + STORE_COLS, base + STORE_COLS + 1};
        sum = 0;
        foreach (corner[k]) begin
            if (!sample_mem[corner[k]][DATA_W]) begin
                res.invalid = 1'b1;
                return res;
            end
            sum += sample_height(sample_mem[corner[k]]);
        end
        // Scaled mode: 1 + floor((C-1)(S-4L)/(4R) + 1/2), worked with doubled terms so
        // that it stays exact in integers. A zero map size counts as one entry.
        if (cmap_size_q == '0) begin
            colors = 1;
        end else begin
            colors = longint'(cmap_size_q);
        end
        span = longint'(span_high) - longint'(span_low);
        if (span < 1) begin
            span = 1;
        end
        num  = (colors - 1) * (sum - 4 * longint'(span_low));
        den  = 4 * span;
        num  = 2 * num + den;
        den  = 2 * den;
        quot = num / den;
        if (num % den != 0 && num < 0) begin
            quot -= 1;
        end
        res.color = clamp_color(1 + quot);
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------------------

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endfunction

    // The receiver holds stall for a random number of cycles before each word, then takes
    // the next word that shows up and compares it with the oldest prediction.
    initial begin : result_check
        int unsigned   hold;
        facet_result_t due;
        facet_result_t seen;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            hold = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            seen.color    = o_color_index;
            seen.invalid  = o_facet_invalid;
            seen.off_grid = o_out_of_grid;
            if (colors_due.size() == 0) begin
                note_mismatch($sformatf("result word with nothing outstanding: colour %0d %s %0b %s %0b",
                                        seen.color, "invalid", seen.invalid,
                                        "off-grid", seen.off_grid));
            end else begin
                due = colors_due.pop_front();
                if (seen.color !== due.color || seen.invalid !== due.invalid ||
                    seen.off_grid !== due.off_grid) begin
                    note_mismatch($sformatf({"expected colour %0d invalid %0b off-grid %0b, ",
                                             "got colour %0d invalid %0b off-grid %0b"},
                                            due.color, due.invalid, due.off_grid,
                                            seen.color, seen.invalid, seen.off_grid));
                end
            end
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------------------

    // Sends one word on the input channel. It is entered and left on a falling edge, and
    // valid stays high into the next word whenever that word has no idle gap in front.
    task automatic send_word(input logic cmd, input int unsigned col, input int unsigned row,
                             input logic [DATA_W-1:0] z, input logic fin,
                             input logic restart);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_col           <= col[COORD_W-1:0];
        i_row           <= row[COORD_W-1:0];
        i_z_value       <= z;
        i_z_finite      <= fin;
        i_restart_range <= restart;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == CMD_LOAD) begin
            store_sample(col, row, z, fin, restart);
        end else begin
            colors_due.push_back(predict_facet(col, row));
        end
        @(negedge i_clk);
    endtask

    task automatic load_sample(input int unsigned col, input int unsigned row,
                               input logic [DATA_W-1:0] z, input logic fin,
                               input logic restart);
        send_word(CMD_LOAD, col, row, z, fin, restart);
    endtask

    // The payload fields that a query does not use carry random junk.
    task automatic query_facet(input int unsigned col, input int unsigned row);
        send_word(CMD_QUERY, col, row, $urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    // Holds the sender back until every predicted colour has been received.
    task automatic await_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (colors_due.size() != 0) @(negedge i_clk);
    endtask

    // Loads leave no trace on the result channel, so after the last result a settling wait
    // is allowed for anything still in flight before the block counts as idle.
    task automatic settle_block();
        await_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes all four registers back to back; only ever called once the block is idle.
    task automatic program_grid(input int unsigned cols, input int unsigned rows,
                                input int unsigned cmap, input bit scaled);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_GRID_COLS, CFG_GRID_ROWS, CFG_CMAP_SIZE, CFG_SCALED_MODE};
        vals = '{cols[CFG_DATA_W-1:0], rows[CFG_DATA_W-1:0], cmap[CFG_DATA_W-1:0],
                 CFG_DATA_W'(scaled)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            case (regs[k])
                CFG_GRID_COLS:   grid_cols_q = vals[k][GRID_W-1:0];
                CFG_GRID_ROWS:   grid_rows_q = vals[k][GRID_W-1:0];
                CFG_CMAP_SIZE:   cmap_size_q = vals[k][CMAP_W-1:0];
                CFG_SCALED_MODE: scaled_q    = vals[k][0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] random_height();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom();
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                // Within about +/-256.0, so that a range of nearby heights is common.
                v = $urandom_range(0, 32'h0200_0000);
                v = v - 32'h0100_0000;
            end
        endcase
        return v;
    endfunction

    // Loads every corner of a facet that has never been written, so that a query never
    // touches an undefined store entry.
    task automatic fill_facet(input int unsigned col, input int unsigned row,
                              inout int unsigned words);
        int unsigned cc;
        int unsigned rr;
        for (int k = 0; k < 4; k++) begin
            cc = col + (k % 2);
            rr = row + (k / 2);
            if (!loaded[rr * STORE_COLS + cc]) begin
                load_sample(cc, rr, random_height(), $urandom_range(0, 9) != 0,
                            $urandom_range(0, 19) == 0);
                words++;
            end
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Straight after reset: a 2 by 2 grid, 32 colours and scaled mode must be in force.
    task automatic test_reset_defaults();
        load_sample(0, 0, 32'h0001_0000, 1'b1, 1'b1);
        load_sample(1, 0, 32'h0003_0000, 1'b1, 1'b0);
        load_sample(0, 1, 32'h0002_0000, 1'b1, 1'b0);
        load_sample(1, 1, 32'h0004_0000, 1'b1, 1'b0);
        query_facet(0, 0);
        query_facet(1, 0);
        query_facet(0, 1);
    endtask

    // Largest grid and map, the most positive and most negative heights in both modes,
    // and truncation of a negative fraction toward zero.
    task automatic test_extremes();
        settle_block();
        program_grid(64, 64, 65535, 1'b1);
        load_sample(62, 62, 32'h7FFF_FFFF, 1'b1, 1'b1);
        load_sample(63, 62, 32'h8000_0000, 1'b1, 1'b0);
        load_sample(62, 63, 32'h7FFF_FFFF, 1'b1, 1'b0);
        load_sample(63, 63, 32'h8000_0000, 1'b1, 1'b0);
        query_facet(62, 62);
        query_facet(63, 10);
        settle_block();
        program_grid(64, 64, 65535, 1'b0);
        query_facet(62, 62);
        load_sample(62, 62, 32'h8000_0000, 1'b1, 1'b0);
        query_facet(62, 62);
        load_sample(62, 62, 32'hFFFE_8000, 1'b1, 1'b0);
        query_facet(62, 62);
    endtask

    // Non-finite corners in both modes, a zero-sized map, a restart that leaves the range
    // empty, and facets beyond the configured grid.
    task automatic test_special_cases();
        settle_block();
        program_grid(4, 4, 0, 1'b1);
        load_sample(0, 0, 32'h0002_0000, 1'b1, 1'b1);
        load_sample(1, 0, 32'h0005_0000, 1'b0, 1'b0);
        load_sample(0, 1, 32'h0001_8000, 1'b1, 1'b0);
        load_sample(1, 1, 32'h0003_0000, 1'b1, 1'b0);
        load_sample(0, 2, 32'h0002_4000, 1'b1, 1'b0);
        load_sample(1, 2, 32'h0001_0000, 1'b1, 1'b0);
        load_sample(2, 0, 32'hFFFF_0000, 1'b1, 1'b0);
        load_sample(2, 1, 32'h0000_8000, 1'b1, 1'b0);
        query_facet(0, 0);
        query_facet(0, 1);
        // A non-finite load with restart clears the range and tracks nothing.
        load_sample(3, 3, 32'h1234_5678, 1'b0, 1'b1);
        query_facet(0, 1);
        settle_block();
        program_grid(4, 4, 300, 1'b1);
        query_facet(0, 1);
        settle_block();
        program_grid(4, 4, 300, 1'b0);
        query_facet(0, 0);
        query_facet(1, 0);
        query_facet(3, 0);
    endtask

    // Phases of random traffic, each under its own configuration. Most words form a
    // well-formed sequence of corner loads followed by a query of that facet; the rest are
    // stray loads anywhere in the store and queries that fall off the configured grid.
    task automatic test_random_traffic();
        int unsigned cols;
        int unsigned rows;
        int unsigned cmap;
        int unsigned words;
        int unsigned fc;
        int unsigned fr;
        bit          scaled;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    cols = 64; rows = 64; cmap = 65535; scaled = 1'b1;
                end
                1: begin
                    cols = 2; rows = 2; cmap = 1; scaled = 1'b0;
                end
                2: begin
                    cols = 64; rows = 2; cmap = 2; scaled = 1'b1;
                end
                default: begin
                    cols = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64)
                                                       : $urandom_range(2, 8);
                    rows = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64)
                                                       : $urandom_range(2, 8);
                    case ($urandom_range(0, 4))
                        0:       cmap = 1;
                        1:       cmap = 65535;
                        2:       cmap = $urandom_range(2, 64);
                        default: cmap = $urandom_range(1, 65535);
                    endcase
                    scaled = $urandom_range(0, 3) != 0;
                end
            endcase
            settle_block();
            program_grid(cols, rows, cmap, scaled);
            tx_steady = $urandom_range(0, 3) == 0;
            rx_steady = $urandom_range(0, 3) == 0;
            words = 0;
            while (words < WORDS_PER_PHASE) begin
                if ($urandom_range(0, 15) == 0) begin
                    tx_steady = $urandom_range(0, 3) == 0;
                    rx_steady = $urandom_range(0, 3) == 0;
                end
                if ($urandom_range(0, 40) == 0) begin
                    await_results();
                end
                case ($urandom_range(0, 9))
                    0, 1: begin
                        load_sample($urandom_range(0, 63), $urandom_range(0, 63),
                                    random_height(), $urandom_range(0, 9) != 0,
                                    $urandom_range(0, 19) == 0);
                        words++;
                    end
                    2: begin
                        if ($urandom_range(0, 1) == 0) begin
                            fc = $urandom_range(cols - 1, 63);
                            fr = $urandom_range(0, 63);
                        end else begin
                            fc = $urandom_range(0, 63);
                            fr = $urandom_range(rows - 1, 63);
                        end
                        query_facet(fc, fr);
                        words++;
                    end
                    default: begin
                        fc = $urandom_range(0, cols - 2);
                        fr = $urandom_range(0, rows - 2);
                        fill_facet(fc, fr, words);
                        query_facet(fc, fr);
                        words++;
                    end
                endcase
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------------------

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_LOAD;
        i_col           = '0;
        i_row           = '0;
        i_z_value       = '0;
        i_z_finite      = 1'b0;
        i_restart_range = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_GRID_COLS;
        i_cfg_data      = '0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        // The model starts from the reset state of the block: range cleared, registers
        // at their defaults, and no store entry yet written.
        span_low        = '0;
        span_high       = '0;
        span_seen       = 1'b0;
        grid_cols_q     = 7'd2;
        grid_rows_q     = 7'd2;
        cmap_size_q     = 16'd32;
        scaled_q        = 1'b1;
        foreach (sample_mem[k]) begin
            sample_mem[k] = '0;
            loaded[k]     = 1'b0;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_extremes();
        test_special_cases();
        test_random_traffic();

        settle_block();
        if (mismatch_count == 0 && colors_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
